// ===== src/mexp_pkg.sv =====
// Shared declarations for the modular exponentiation block.
// Register indexes, fixed reset values, command codes and the multiplier status struct.
// No dependencies.
package mexp_pkg;

  localparam int unsigned CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS          = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRIVATE_EXPONENT = 2'd2;

  localparam logic [31:0] MODULUS_RESET  = 32'd16587;
  localparam logic [31:0] EXPONENT_RESET = 32'd1;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_stat_t;

endpackage

// ===== src/mexp_modmul.sv =====
// Bit-serial modular multiplier: product = op_x * op_y mod modulus.
// Consumes one bit of op_x per cycle, MSB first; op_y must be below modulus.
// Depends on mexp_pkg.
module mexp_modmul
  import mexp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] op_x,
  input  logic [VALUE_WIDTH-1:0] op_y,
  input  logic [VALUE_WIDTH-1:0] modulus,
  output logic [VALUE_WIDTH-1:0] product,
  output mexp_mul_stat_t         stat
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic                   busy_r;
  logic                   done_r;
  logic [CW-1:0]          cnt_r;
  logic [VALUE_WIDTH-1:0] x_r;
  logic [VALUE_WIDTH-1:0] y_r;
  logic [VALUE_WIDTH-1:0] acc_r;

  logic [VALUE_WIDTH:0]   dbl;
  logic [VALUE_WIDTH:0]   m_ext;
  logic [VALUE_WIDTH:0]   red1;
  logic [VALUE_WIDTH:0]   addend;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH:0]   red2;

  always_comb begin
    dbl    = {acc_r, 1'b0};
    m_ext  = {1'b0, modulus};
    red1   = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    addend = x_r[VALUE_WIDTH-1] ? {1'b0, y_r} : '0;
    sum    = {1'b0, red1[VALUE_WIDTH-1:0]} + addend;
    red2   = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(VALUE_WIDTH - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= op_x;
      y_r   <= op_y;
      acc_r <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[VALUE_WIDTH-2:0], 1'b0};
      acc_r <= red2[VALUE_WIDTH-1:0];
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== src/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: registers, sequencer, result stage.
// Depends on mexp_pkg and mexp_modmul.
//
// Each input beat gives base_value ^ exponent mod modulus, the exponent chosen by cmd
// (0 public, 1 private). An exponent of 0 gives 1; a modulus of 0 gives 0 otherwise.
// The base is first reduced, then square-and-multiply runs from the exponent LSB, every
// multiply going through one bit-serial modular multiplier. An item takes
// (1 + popcount(e) + bitlen(e) - 1) multiplies; one item is worked on at a time, and the
// next is taken while the previous result waits.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [VALUE_WIDTH-1:0]     cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [VALUE_WIDTH-1:0]     in_base_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VALUE_WIDTH-1:0]     out_power_result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_BIT,
    S_ACC,
    S_SQR,
    S_DONE
  } state_t;

  localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

  logic [VALUE_WIDTH-1:0] modulus_r;
  logic [VALUE_WIDTH-1:0] pub_exp_r;
  logic [VALUE_WIDTH-1:0] priv_exp_r;

  state_t                 state_r,     state_nxt;
  logic [VALUE_WIDTH-1:0] e_r,         e_nxt;
  logic [VALUE_WIDTH-1:0] acc_r,       acc_nxt;
  logic [VALUE_WIDTH-1:0] sq_r,        sq_nxt;
  logic [VALUE_WIDTH-1:0] res_r,       res_nxt;
  logic [VALUE_WIDTH-1:0] opx_r,       opx_nxt;
  logic [VALUE_WIDTH-1:0] opy_r,       opy_nxt;
  logic                   start_r,     start_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_res_r,   out_res_nxt;

  logic [VALUE_WIDTH-1:0] mul_product;
  mexp_mul_stat_t         mul_stat;

  logic [VALUE_WIDTH-1:0] sel_exp;
  logic [VALUE_WIDTH-1:0] one_mod;
  logic [VALUE_WIDTH-1:0] e_shift;
  logic [VALUE_WIDTH-1:0] acc_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MODULUS_RESET[VALUE_WIDTH-1:0];
      pub_exp_r  <= EXPONENT_RESET[VALUE_WIDTH-1:0];
      priv_exp_r <= EXPONENT_RESET[VALUE_WIDTH-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:          modulus_r  <= cfg_wdata;
        REG_PUBLIC_EXPONENT:  pub_exp_r  <= cfg_wdata;
        REG_PRIVATE_EXPONENT: priv_exp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mexp_modmul #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .op_x    (opx_r),
    .op_y    (opy_r),
    .modulus (modulus_r),
    .product (mul_product),
    .stat    (mul_stat)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

  always_comb begin
    sel_exp   = (in_cmd == CMD_DECRYPT) ? priv_exp_r : pub_exp_r;
    one_mod   = (modulus_r == ONE) ? '0 : ONE;
    e_shift   = {1'b0, e_r[VALUE_WIDTH-1:1]};
    acc_after = (state_r == S_ACC) ? mul_product : acc_r;

    state_nxt     = state_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    opx_nxt       = opx_r;
    opy_nxt       = opy_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sel_exp == '0) begin
            res_nxt   = ONE;
            state_nxt = S_DONE;
          end else if (modulus_r == '0) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            e_nxt     = sel_exp;
            acc_nxt   = one_mod;
            opx_nxt   = in_base_value;
            opy_nxt   = one_mod;
            start_nxt = 1'b1;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (mul_stat.done) begin
          sq_nxt    = mul_product;
          state_nxt = S_BIT;
        end
      end
      S_BIT, S_ACC: begin
        if (state_r == S_BIT && e_r[0]) begin
          opx_nxt   = acc_r;
          opy_nxt   = sq_r;
          start_nxt = 1'b1;
          state_nxt = S_ACC;
        end else if (state_r == S_BIT || mul_stat.done) begin
          acc_nxt = acc_after;
          e_nxt   = e_shift;
          if (e_shift == '0) begin
            res_nxt   = acc_after;
            state_nxt = S_DONE;
          end else begin
            opx_nxt   = sq_r;
            opy_nxt   = sq_r;
            start_nxt = 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mul_stat.done) begin
          sq_nxt    = mul_product;
          state_nxt = S_BIT;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    res_r     <= res_nxt;
    opx_r     <= opx_nxt;
    opy_r     <= opy_nxt;
    out_res_r <= out_res_nxt;
  end

`ifndef SYNTH
  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_RED || state_r == S_ACC || state_r == S_SQR))
    else $error("multiplier finished outside a waiting state");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_out_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result beat raised without a finished item");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");
`endif

endmodule
